// ----- design/life_generation_step_defines.svh -----
// Assertion macros shared by the life generation step RTL.
`ifndef LIFE_GENERATION_STEP_DEFINES_SVH
`define LIFE_GENERATION_STEP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define LGS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lgs_pkg.sv -----
// Shared widths, window types and tap controls for the life generation step.
`default_nettype none

package lgs_pkg;

  localparam int BYTE_W    = 8;
  localparam int OUT_ROW_W = 7;
  localparam int OUT_COL_W = 4;

  typedef logic [BYTE_W-1:0] cell_byte_t;

  // One row of the 3x3 window seen by a byte: bit 0 is the cell left of the
  // byte, bits 8..1 are the byte itself, the top bit is the cell to its right.
  typedef logic [BYTE_W+1:0] win_row_t;

  typedef struct packed {
    win_row_t up;
    win_row_t mid;
    win_row_t dn;
  } window_t;

  typedef struct packed {
    logic second;
    logic up_valid;
    logic left_valid;
  } tap_ctl_t;

endpackage

`default_nettype wire

// ----- design/lgs_if.sv -----
// Valid/ready stream interfaces for the cell input and the result output.
`default_nettype none

interface lgs_in_if import lgs_pkg::*; ();
  logic       valid;
  logic       ready;
  cell_byte_t cell_byte;
  logic       frame_start;

  modport source (output valid, output cell_byte, output frame_start, input ready);
  modport sink (input valid, input cell_byte, input frame_start, output ready);
endinterface

interface lgs_out_if import lgs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cell_byte_t           next_byte;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_column_byte;
  logic                 last_of_run;
  logic                 frame_done;

  modport source (output valid, output next_byte, output out_row, output out_column_byte,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input next_byte, input out_row, input out_column_byte,
                input last_of_run, input frame_done, output ready);
endinterface

`default_nettype wire

// ----- design/life_generation_step.sv -----
// Life generation step top level: streams a B3/S23 frame in, next generation out.
// The input channel carries one byte of eight cells per transfer, in raster
// order, bit i being column 8*byte+i; frame_start marks the first byte of a
// frame and restarts the position counters. The output channel carries one
// next-generation byte per transfer with its row, byte index, a last_of_run
// flag on the final result caused by an input, and frame_done on the very
// last byte of the frame. Inside a row the block takes one byte per cycle unless
// the receiver stalls; the last byte of a row yields two results and so holds
// the input while the first is issued, and the last byte of the frame yields
// two plus one row of results, during which the input is held while a dead row
// is shifted through the window. All of this is set by the one shared lane
// array and output register, which turn out one result per cycle unless the
// receiver stalls. Reset is synchronous and leaves the block at row 0, byte 0,
// with no result pending. When the receiver stalls, the result waits in the
// output register; the first input that owes a result then waits in the step
// register, after which ready drops until the result is taken.
`default_nettype none
`include "life_generation_step_defines.svh"

module life_generation_step import lgs_pkg::*; #(
  parameter int GRID_COLUMNS = 96,
  parameter int GRID_ROWS    = 96
) (
  input  logic       clk,
  input  logic       rst_n,
  lgs_in_if.sink     in_stream,
  lgs_out_if.source  out_stream
);

  localparam int BPR   = (GRID_COLUMNS + BYTE_W - 1) / BYTE_W;
  localparam int COL_W = (BPR > 1) ? $clog2(BPR) : 1;
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int TAIL  = GRID_COLUMNS % BYTE_W;
  localparam cell_byte_t LAST_MASK = (TAIL == 0) ? '1 : BYTE_W'((1 << TAIL) - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(BPR - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

  // Input position counters.
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;

  // Dead-row flush that follows the last byte of a frame.
  logic             flush_active_r, flush_active_nxt;
  logic [COL_W-1:0] flush_col_r, flush_col_nxt;

  // Step register: the jobs that the last shifted byte still owes the output.
  // Job A is byte (row-1, col-1), job B is byte (row-1, col) at the row end.
  logic             job_a_r, job_a_nxt;
  logic             job_b_r, job_b_nxt;
  logic [COL_W-1:0] step_col_r, step_col_nxt;
  logic [ROW_W-1:0] step_row_r, step_row_nxt;
  logic             step_up_ok_r, step_up_ok_nxt;
  logic             step_quiet_r, step_quiet_nxt;
  logic             step_done_r, step_done_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  cell_byte_t           next_byte_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic                 last_of_run_r;
  logic                 frame_done_r;

  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_final;
  logic             step_busy;
  logic             out_free;
  logic             issue_fire;
  logic             step_free;
  logic             in_ready;
  logic             in_fire;
  logic             flush_fire;
  logic             load;
  cell_byte_t       push_byte;
  logic             issue_second;
  logic             issue_last;
  logic [COL_W-1:0] issue_col;
  tap_ctl_t         tap_ctl;
  window_t          win;
  cell_byte_t       result_mask;
  cell_byte_t       result_byte;

  // A frame start takes its byte as row 0, byte 0, whatever the counters say.
  assign in_row   = in_stream.frame_start ? '0 : row_cnt_r;
  assign in_col   = in_stream.frame_start ? '0 : col_cnt_r;
  assign in_final = (in_row == LAST_ROW) && (in_col == LAST_COL);

  // The window must not move while a job of the current step is still owed,
  // so a new byte is shifted in only once the step register empties.
  assign step_busy  = job_a_r | job_b_r;
  assign out_free   = !out_valid_r || out_stream.ready;
  assign issue_fire = step_busy && out_free;
  assign step_free  = !step_busy || (issue_fire && !(job_a_r && job_b_r));
  assign in_ready   = step_free && !flush_active_r;
  assign in_fire    = in_stream.valid && in_ready;
  assign flush_fire = flush_active_r && step_free;
  assign load       = in_fire || flush_fire;

  // Bits past the grid are stored as dead cells; the flush shifts a dead row.
  assign push_byte = in_fire
                   ? (in_stream.cell_byte & ((in_col == LAST_COL) ? LAST_MASK : '1))
                   : '0;

  assign in_stream.ready = in_ready;

  // Job A goes first; job B reuses the same window taps one column over.
  assign issue_second = !job_a_r;
  assign issue_last   = !job_a_r || !job_b_r;
  assign issue_col    = issue_second ? step_col_r : (step_col_r - COL_W'(1));
  assign tap_ctl      = '{second: issue_second, up_valid: step_up_ok_r,
                          left_valid: (issue_col != '0)};
  assign result_mask  = (issue_col == LAST_COL) ? LAST_MASK : '1;

  lgs_row_window #(
    .BYTES_PER_ROW (BPR)
  ) u_row_window (
    .clk       (clk),
    .push      (load),
    .push_byte (push_byte),
    .tap_ctl   (tap_ctl),
    .win       (win)
  );

  lgs_lane_merge u_lane_merge (
    .win       (win),
    .col_mask  (result_mask),
    .next_byte (result_byte)
  );

  // Position counters and flush sequencing.
  always_comb begin
    row_cnt_nxt      = row_cnt_r;
    col_cnt_nxt      = col_cnt_r;
    flush_active_nxt = flush_active_r;
    flush_col_nxt    = flush_col_r;
    if (in_fire) begin
      if (in_col == LAST_COL) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = (in_row == LAST_ROW) ? '0 : (in_row + ROW_W'(1));
      end else begin
        col_cnt_nxt = in_col + COL_W'(1);
        row_cnt_nxt = in_row;
      end
      if (in_final) begin
        flush_active_nxt = 1'b1;
        flush_col_nxt    = '0;
      end
    end
    if (flush_fire) begin
      if (flush_col_r == LAST_COL) begin
        flush_active_nxt = 1'b0;
      end else begin
        flush_col_nxt = flush_col_r + COL_W'(1);
      end
    end
  end

  // Step register: a new step is loaded only when nothing is owed any more.
  always_comb begin
    job_a_nxt      = job_a_r;
    job_b_nxt      = job_b_r;
    step_col_nxt   = step_col_r;
    step_row_nxt   = step_row_r;
    step_up_ok_nxt = step_up_ok_r;
    step_quiet_nxt = step_quiet_r;
    step_done_nxt  = step_done_r;
    if (issue_fire) begin
      if (job_a_r) begin
        job_a_nxt = 1'b0;
      end else begin
        job_b_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      job_a_nxt      = (in_row != '0) && (in_col != '0);
      job_b_nxt      = (in_row != '0) && (in_col == LAST_COL);
      step_col_nxt   = in_col;
      step_row_nxt   = in_row - ROW_W'(1);
      step_up_ok_nxt = (in_row >= ROW_W'(2));
      // The frame's last byte is not the end of its run: the flush follows.
      step_quiet_nxt = in_final;
      step_done_nxt  = 1'b0;
    end else if (flush_fire) begin
      job_a_nxt      = (flush_col_r != '0);
      job_b_nxt      = (flush_col_r == LAST_COL);
      step_col_nxt   = flush_col_r;
      step_row_nxt   = LAST_ROW;
      step_up_ok_nxt = 1'b1;
      // The whole flush belongs to the frame's last input, so only its final
      // step closes the run.
      step_quiet_nxt = (flush_col_r != LAST_COL);
      step_done_nxt  = (flush_col_r == LAST_COL);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (issue_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r      <= '0;
      col_cnt_r      <= '0;
      flush_active_r <= 1'b0;
      flush_col_r    <= '0;
      job_a_r        <= 1'b0;
      job_b_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      row_cnt_r      <= row_cnt_nxt;
      col_cnt_r      <= col_cnt_nxt;
      flush_active_r <= flush_active_nxt;
      flush_col_r    <= flush_col_nxt;
      job_a_r        <= job_a_nxt;
      job_b_r        <= job_b_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Step and result payload carry no reset; the job bits and valid guard them.
  always_ff @(posedge clk) begin
    step_col_r   <= step_col_nxt;
    step_row_r   <= step_row_nxt;
    step_up_ok_r <= step_up_ok_nxt;
    step_quiet_r <= step_quiet_nxt;
    step_done_r  <= step_done_nxt;
    if (issue_fire) begin
      next_byte_r   <= result_byte;
      out_row_r     <= OUT_ROW_W'(step_row_r);
      out_col_r     <= OUT_COL_W'(issue_col);
      last_of_run_r <= issue_last && !step_quiet_r;
      frame_done_r  <= issue_last && step_done_r;
    end
  end

  assign out_stream.valid           = out_valid_r;
  assign out_stream.next_byte       = next_byte_r;
  assign out_stream.out_row         = out_row_r;
  assign out_stream.out_column_byte = out_col_r;
  assign out_stream.last_of_run     = last_of_run_r;
  assign out_stream.frame_done      = frame_done_r;

  `LGS_ASSERT_IMPL(a_done_is_row_end, out_valid_r && frame_done_r,
                   last_of_run_r && (out_col_r == OUT_COL_W'(LAST_COL)),
                   "frame_done off the last byte of a run")
  `LGS_ASSERT_IMPL(a_window_holds, load && step_busy,
                   issue_fire && !(job_a_r && job_b_r),
                   "window shifted under an owed job")
  `LGS_ASSERT_NEXT(a_flush_follows_final, in_fire && in_final,
                   flush_active_r && (flush_col_r == '0),
                   "no flush after the frame's last byte")
  `LGS_ASSERT_IMPL(a_job_b_at_row_end, job_b_r, step_col_r == LAST_COL,
                   "row-end job away from the last byte")

endmodule

`default_nettype wire

// ----- design/lgs_row_window.sv -----
// Byte shift line over two rows plus three bytes, with the 3x3 window taps.
`default_nettype none

module lgs_row_window import lgs_pkg::*; #(
  parameter int BYTES_PER_ROW = 12
) (
  input  logic       clk,
  input  logic       push,
  input  cell_byte_t push_byte,
  input  tap_ctl_t   tap_ctl,
  output window_t    win
);

  localparam int DEPTH    = 2 * BYTES_PER_ROW + 3;
  localparam int MID_BASE = BYTES_PER_ROW;
  localparam int UP_BASE  = 2 * BYTES_PER_ROW;

  cell_byte_t line_r [DEPTH];

  // Index 0 is the newest byte; index base+k is column (current - k) of that row.
  always_ff @(posedge clk) begin
    if (push) begin
      line_r[0] <= push_byte;
      for (int k = 1; k < DEPTH; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  function automatic win_row_t tap_row(cell_byte_t near_b, cell_byte_t mid_b,
                                       cell_byte_t far_b, tap_ctl_t ctl);
    logic       left;
    cell_byte_t centre;
    logic       right;
    if (ctl.second) begin
      left   = mid_b[BYTE_W-1];
      centre = near_b;
      right  = 1'b0;
    end else begin
      left   = far_b[BYTE_W-1];
      centre = mid_b;
      right  = near_b[0];
    end
    left = left & ctl.left_valid;
    return {right, centre, left};
  endfunction

  always_comb begin
    win.dn  = tap_row(line_r[0], line_r[1], line_r[2], tap_ctl);
    win.mid = tap_row(line_r[MID_BASE], line_r[MID_BASE+1], line_r[MID_BASE+2], tap_ctl);
    win.up  = tap_ctl.up_valid
            ? tap_row(line_r[UP_BASE], line_r[UP_BASE+1], line_r[UP_BASE+2], tap_ctl)
            : '0;
  end

endmodule

`default_nettype wire

// ----- design/lgs_lane.sv -----
// One cell lane: counts the eight neighbors and applies the B3/S23 rule.
`default_nettype none

module lgs_lane (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] dn,
  output logic       next_cell
);

  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  logic [NBR_W-1:0] count;

  assign count = NBR_W'(up[0]) + NBR_W'(up[1]) + NBR_W'(up[2])
               + NBR_W'(mid[0]) + NBR_W'(mid[2])
               + NBR_W'(dn[0]) + NBR_W'(dn[1]) + NBR_W'(dn[2]);

  assign next_cell = (count == BIRTH_COUNT) || (mid[1] && (count == SURVIVE_COUNT));

endmodule

`default_nettype wire

// ----- design/lgs_lane_merge.sv -----
// Eight cell lanes side by side and the stage that merges them into a byte.
`default_nettype none

module lgs_lane_merge import lgs_pkg::*; (
  input  window_t    win,
  input  cell_byte_t col_mask,
  output cell_byte_t next_byte
);

  cell_byte_t lane_bits;

  for (genvar i = 0; i < BYTE_W; i++) begin : g_lane
    lgs_lane u_lane (
      .up        (win.up[i+2:i]),
      .mid       (win.mid[i+2:i]),
      .dn        (win.dn[i+2:i]),
      .next_cell (lane_bits[i])
    );
  end

  // Cells past the right edge of the grid are always dead.
  assign next_byte = lane_bits & col_mask;

endmodule

`default_nettype wire

// ----- tb/life_generation_step_test.sv -----
// Self-checking testbench for the streaming Game of Life generation step.
`timescale 1ns / 100ps

module life_generation_step_test;
  import lgs_pkg::*;

  // Grid size under test; the block gets the same values.
  localparam int COLUMNS     = 96;
  localparam int ROWS        = 96;
  localparam int ROW_BYTES   = (COLUMNS + 7) / 8;

  localparam int RESET_CYCLES    = 11;
  localparam int IDLE_PERCENT    = 15;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SHORT_BUDGET    = 120;
  localparam int FULL_RATE_BYTES = 10 * ROW_BYTES;

  // Column codes of the opening table.
  localparam logic START     = 1'b1;
  localparam logic CARRY_ON  = 1'b0;
  localparam logic NO_RESULT = 1'b1;
  localparam logic PREDICTED = 1'b0;

  // Content styles for random cell bytes.
  localparam int unsigned MIX_UNIFORM = 0;
  localparam int unsigned MIX_SPARSE  = 1;
  localparam int unsigned MIX_DENSE   = 2;
  localparam int unsigned MIX_BLOCKY  = 3;

  typedef logic [COLUMNS-1:0] cell_row_t;

  typedef struct packed {
    cell_byte_t           next_byte;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] column_byte;
    logic                 last_of_run;
    logic                 frame_done;
  } life_result_t;

  typedef struct packed {
    cell_byte_t cells;
    logic       frame_start;
    logic       no_result;
  } opening_row_t;

  // The opening rows. The first twelve bytes arrive right after reset with no
  // frame start flag, so the block must treat them as row 0 on its own; row 0
  // never causes a result, which is typed in here. Row 1 then releases the
  // next generation of row 0, with two results on its last byte. Two bytes of
  // row 2 follow, and a frame start in the middle of row 2 drops the partial
  // frame; that byte is again row 0 of a fresh frame and causes nothing.
  localparam opening_row_t OPENING [27] = '{
    '{8'hFF, CARRY_ON, NO_RESULT}, '{8'h00, CARRY_ON, NO_RESULT},
    '{8'h01, CARRY_ON, NO_RESULT}, '{8'h80, CARRY_ON, NO_RESULT},
    '{8'hAA, CARRY_ON, NO_RESULT}, '{8'h55, CARRY_ON, NO_RESULT},
    '{8'h0F, CARRY_ON, NO_RESULT}, '{8'hF0, CARRY_ON, NO_RESULT},
    '{8'h81, CARRY_ON, NO_RESULT}, '{8'h7E, CARRY_ON, NO_RESULT},
    '{8'hFF, CARRY_ON, NO_RESULT}, '{8'hFF, CARRY_ON, NO_RESULT},
    '{8'h00, CARRY_ON, PREDICTED}, '{8'hFF, CARRY_ON, PREDICTED},
    '{8'h18, CARRY_ON, PREDICTED}, '{8'h3C, CARRY_ON, PREDICTED},
    '{8'h80, CARRY_ON, PREDICTED}, '{8'h01, CARRY_ON, PREDICTED},
    '{8'hFF, CARRY_ON, PREDICTED}, '{8'h00, CARRY_ON, PREDICTED},
    '{8'hE7, CARRY_ON, PREDICTED}, '{8'h24, CARRY_ON, PREDICTED},
    '{8'hC3, CARRY_ON, PREDICTED}, '{8'hFF, CARRY_ON, PREDICTED},
    '{8'h7E, CARRY_ON, PREDICTED}, '{8'h99, CARRY_ON, PREDICTED},
    '{8'h5A, START,    NO_RESULT}
  };

  logic clk;
  logic rst_n;

  lgs_in_if  in_stream ();
  lgs_out_if out_stream ();

  life_generation_step #(
    .GRID_COLUMNS(COLUMNS),
    .GRID_ROWS   (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .out_stream(out_stream)
  );

  // Random idling on each side; both are switched off for a run of ten rows
  // so that the block also sees a long stretch at full rate.
  logic in_gaps_on;
  logic out_stalls_on;

  int mismatch_count;

  // Next-generation bytes that the block still owes, oldest first.
  life_result_t pending_generation[$];
  // Results caused by the most recent input byte, as worked out below.
  life_result_t caused_by_byte[$];

  // Our own copy of the sliding three-row window and the raster position.
  cell_row_t   window_up;
  cell_row_t   window_mid;
  cell_row_t   window_new;
  int unsigned raster_row;
  int unsigned raster_byte;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results.
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Cells outside the grid are dead.
  function automatic int cell_at(input cell_row_t cells, input int x);
    if (x < 0 || x >= COLUMNS) begin
      return 0;
    end
    return int'(cells[x]);
  endfunction

  // Next generation of one byte of the middle row under B3/S23.
  function automatic cell_byte_t evolve_byte(input cell_row_t up, input cell_row_t mid,
                                             input cell_row_t dn, input int col_byte);
    cell_byte_t born;
    int         x;
    int         neighbours;
    born = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      x = BYTE_W * col_byte + i;
      if (x < COLUMNS) begin
        neighbours = 0;
        for (int dx = -1; dx <= 1; dx++) begin
          neighbours += cell_at(up, x + dx) + cell_at(dn, x + dx);
          if (dx != 0) begin
            neighbours += cell_at(mid, x + dx);
          end
        end
        if (neighbours == 3 || (mid[x] && neighbours == 2)) begin
          born[i] = 1'b1;
        end
      end
    end
    return born;
  endfunction

  function automatic void note_generation_byte(input cell_byte_t cells, input int row,
                                               input int col_byte, input logic done);
    life_result_t entry;
    entry.next_byte   = cells;
    entry.row         = OUT_ROW_W'(row);
    entry.column_byte = OUT_COL_W'(col_byte);
    entry.last_of_run = 1'b0;
    entry.frame_done  = done;
    caused_by_byte.push_back(entry);
  endfunction

  // Takes one input byte into the window and lists the bytes it releases:
  // byte (r-1, b-1) once (r, b) has arrived, the last byte of row r-1 with the
  // last byte of row r, and on the frame's final byte the whole last row too,
  // with a dead row below it.
  function automatic void predict_next_generation(input cell_byte_t cells, input logic fs);
    int           r;
    int           b;
    life_result_t tail;
    caused_by_byte.delete();
    if (fs) begin
      raster_row  = 0;
      raster_byte = 0;
    end
    r = int'(raster_row);
    b = int'(raster_byte);

    if (r == 0 && b == 0) begin
      window_up  = '0;
      window_mid = '0;
      window_new = '0;
    end else if (b == 0) begin
      window_up  = window_mid;
      window_mid = window_new;
      window_new = '0;
    end
    for (int i = 0; i < BYTE_W; i++) begin
      if (BYTE_W * b + i < COLUMNS) begin
        window_new[BYTE_W * b + i] = cells[i];
      end
    end

    if (r >= 1) begin
      if (b >= 1) begin
        note_generation_byte(evolve_byte(window_up, window_mid, window_new, b - 1),
                             r - 1, b - 1, 1'b0);
      end
      if (b == ROW_BYTES - 1) begin
        note_generation_byte(evolve_byte(window_up, window_mid, window_new, b),
                             r - 1, b, 1'b0);
      end
    end
    if (r == ROWS - 1 && b == ROW_BYTES - 1) begin
      for (int c = 0; c < ROW_BYTES; c++) begin
        note_generation_byte(evolve_byte(window_mid, window_new, '0, c), r, c,
                             c == ROW_BYTES - 1);
      end
    end
    if (caused_by_byte.size() > 0) begin
      tail = caused_by_byte.pop_back();
      tail.last_of_run = 1'b1;
      caused_by_byte.push_back(tail);
    end

    b++;
    if (b > ROW_BYTES - 1) begin
      b = 0;
      r++;
      if (r >= ROWS) begin
        r = 0;
      end
    end
    raster_row  = r;
    raster_byte = b;
  endfunction

  function automatic cell_byte_t random_cells(input int unsigned mix);
    case (mix)
      MIX_UNIFORM: return cell_byte_t'($urandom);
      MIX_SPARSE:  return cell_byte_t'($urandom & $urandom & $urandom);
      MIX_DENSE:   return cell_byte_t'($urandom | $urandom);
      default:     return ($urandom_range(3) == 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Offers one byte, possibly after a few idle cycles, and holds it until the
  // transfer. The window is advanced at that very edge. For a byte whose lack
  // of results is typed into the table, any result it causes is unexpected.
  task automatic send_cell_byte(input cell_byte_t cells, input logic fs,
                                input logic no_result);
    while (in_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_stream.valid <= 1'b0;
      @(posedge clk);
    end
    in_stream.valid       <= 1'b1;
    in_stream.cell_byte   <= cells;
    in_stream.frame_start <= fs;
    do begin
      @(posedge clk);
    end while (!in_stream.ready);
    predict_next_generation(cells, fs);
    if (!no_result) begin
      foreach (caused_by_byte[i]) begin
        pending_generation.push_back(caused_by_byte[i]);
      end
    end
  endtask

  // Result side. Besides random stalls it twice refuses every transfer for a
  // long stretch, counted here, so the output register and the step register
  // fill and the block has to drop its input ready while bytes keep coming.
  initial begin : result_sink
    int taken;
    int hold_left;
    taken     = 0;
    hold_left = 0;
    out_stream.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_stream.valid && out_stream.ready) begin
        taken++;
        if (taken == 30 || taken == 80) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stream.ready <= 1'b0;
      end else begin
        out_stream.ready <= !(out_stalls_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Every result transfer is matched against the oldest byte still owed.
  always @(posedge clk) begin : result_check
    life_result_t want;
    if (rst_n && out_stream.valid && out_stream.ready) begin
      if (pending_generation.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: row %0d byte %0d value %02h",
                                out_stream.out_row, out_stream.out_column_byte,
                                out_stream.next_byte));
      end else begin
        want = pending_generation.pop_front();
        if (out_stream.next_byte !== want.next_byte) begin
          flag_mismatch($sformatf("row %0d byte %0d: next_byte %02h, expected %02h",
                                  want.row, want.column_byte, out_stream.next_byte,
                                  want.next_byte));
        end
        if (out_stream.out_row !== want.row) begin
          flag_mismatch($sformatf("out_row %0d, expected %0d", out_stream.out_row,
                                  want.row));
        end
        if (out_stream.out_column_byte !== want.column_byte) begin
          flag_mismatch($sformatf("row %0d: out_column_byte %0d, expected %0d", want.row,
                                  out_stream.out_column_byte, want.column_byte));
        end
        if (out_stream.last_of_run !== want.last_of_run) begin
          flag_mismatch($sformatf("row %0d byte %0d: last_of_run %b, expected %b",
                                  want.row, want.column_byte, out_stream.last_of_run,
                                  want.last_of_run));
        end
        if (out_stream.frame_done !== want.frame_done) begin
          flag_mismatch($sformatf("row %0d byte %0d: frame_done %b, expected %b",
                                  want.row, want.column_byte, out_stream.frame_done,
                                  want.frame_done));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned mix;
    int unsigned span;
    int unsigned short_sent;
    mismatch_count        = 0;
    in_gaps_on            = 1'b1;
    out_stalls_on         = 1'b1;
    window_up             = '0;
    window_mid            = '0;
    window_new            = '0;
    raster_row            = 0;
    raster_byte           = 0;
    rst_n                 <= 1'b0;
    in_stream.valid       <= 1'b0;
    in_stream.cell_byte   <= '0;
    in_stream.frame_start <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < $size(OPENING); k++) begin
      send_cell_byte(OPENING[k].cells, OPENING[k].frame_start, OPENING[k].no_result);
    end

    // Short frames of random length, each mostly opened by a frame start in
    // the middle of the previous one; now and then the flag is left off and
    // the bytes simply carry on the running frame.
    short_sent = 0;
    while (short_sent < SHORT_BUDGET) begin
      mix  = $urandom_range(MIX_BLOCKY);
      span = $urandom_range(1, 3 * ROW_BYTES + 4);
      for (int k = 0; k < span; k++) begin
        send_cell_byte(random_cells(mix), k == 0 && $urandom_range(7) != 0, 1'b0);
      end
      short_sent += span;
    end

    // Ten rows at full rate on both sides, opened by a frame start.
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    mix = $urandom_range(MIX_BLOCKY);
    for (int k = 0; k < FULL_RATE_BYTES; k++) begin
      send_cell_byte(random_cells(mix), k == 0, 1'b0);
    end
    in_stream.valid <= 1'b0;

    while (pending_generation.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- life_generation_step.f -----
+incdir+design
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_row_window.sv
design/lgs_lane.sv
design/lgs_lane_merge.sv
design/life_generation_step.sv
tb/life_generation_step_test.sv
